[design/xibe_pkg.sv]
// Package for the x86 instruction byte encoder.
// Holds the item, result and queue entry types and the shared codes.
// No dependencies.
`default_nettype none
package xibe_pkg;

   localparam int ADDR_BITS = 32;
   localparam int MAX_BYTES = 11;
   localparam int IDX_BITS  = $clog2(MAX_BYTES);

   // Operand kinds.
   localparam logic [2:0] K_NONE  = 3'd0;
   localparam logic [2:0] K_IMM   = 3'd1;
   localparam logic [2:0] K_REG   = 3'd2;
   localparam logic [2:0] K_RMEM  = 3'd3;
   localparam logic [2:0] K_MEM   = 3'd4;
   localparam logic [2:0] K_LABEL = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   // Operation codes, densely numbered.
   localparam logic [5:0] A_PUSH    = 6'd0;
   localparam logic [5:0] A_POP     = 6'd1;
   localparam logic [5:0] A_MOV     = 6'd2;
   localparam logic [5:0] A_CMP     = 6'd3;
   localparam logic [5:0] A_JMP     = 6'd4;
   localparam logic [5:0] A_JZ      = 6'd5;
   localparam logic [5:0] A_JNE     = 6'd6;
   localparam logic [5:0] A_JG      = 6'd7;
   localparam logic [5:0] A_JGE     = 6'd8;
   localparam logic [5:0] A_JL      = 6'd9;
   localparam logic [5:0] A_JLE     = 6'd10;
   localparam logic [5:0] A_JNB     = 6'd11;
   localparam logic [5:0] A_JNBE    = 6'd12;
   localparam logic [5:0] A_JNA     = 6'd13;
   localparam logic [5:0] A_JNAE    = 6'd14;
   localparam logic [5:0] A_RET     = 6'd15;
   localparam logic [5:0] A_LEAVE   = 6'd16;
   localparam logic [5:0] A_CALL    = 6'd17;
   localparam logic [5:0] A_ADD     = 6'd18;
   localparam logic [5:0] A_SUB     = 6'd19;
   localparam logic [5:0] A_AND     = 6'd20;
   localparam logic [5:0] A_OR      = 6'd21;
   localparam logic [5:0] A_XOR     = 6'd22;
   localparam logic [5:0] A_NOT     = 6'd23;
   localparam logic [5:0] A_NOP     = 6'd24;
   localparam logic [5:0] A_PUSHAD  = 6'd25;
   localparam logic [5:0] A_POPAD   = 6'd26;
   localparam logic [5:0] A_IMUL    = 6'd27;
   localparam logic [5:0] A_IDIV    = 6'd28;
   localparam logic [5:0] A_LEA     = 6'd29;
   localparam logic [5:0] A_FLD     = 6'd30;
   localparam logic [5:0] A_FST     = 6'd31;
   localparam logic [5:0] A_FSTP    = 6'd32;
   localparam logic [5:0] A_FILD    = 6'd33;
   localparam logic [5:0] A_FADD    = 6'd34;
   localparam logic [5:0] A_FSUB    = 6'd35;
   localparam logic [5:0] A_FMUL    = 6'd36;
   localparam logic [5:0] A_FDIV    = 6'd37;
   localparam logic [5:0] A_FUCOMPP = 6'd38;
   localparam logic [5:0] A_FNSTSW  = 6'd39;
   localparam logic [5:0] A_SAHF    = 6'd40;
   localparam logic [5:0] A_FSQRT   = 6'd41;
   localparam logic [5:0] A_INT3    = 6'd42;
   localparam logic [5:0] A_PUSHF   = 6'd43;
   localparam logic [5:0] A_POPF    = 6'd44;
   localparam logic [5:0] A_NONE    = 6'd45;

   typedef struct packed {
      logic [5:0]         action;
      logic [2:0]         dst_kind;
      logic signed [31:0] dst_value;
      logic [2:0]         src_kind;
      logic signed [31:0] src_value;
      logic signed [31:0] mem_offset;
      logic [1:0]         mem_scale;
      logic [2:0]         mem_index;
      logic [31:0]        label_address;
      logic               use_label_imm;
   } req_type;

   typedef struct packed {
      logic [7:0]  code_byte;
      logic        last_byte;
      logic [1:0]  status;
      logic [31:0] instr_address;
   } rsp_type;

   // One encoded instruction waiting between the front and back ends.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [IDX_BITS-1:0]       len;
      logic [1:0]                status;
      logic [31:0]               start;
   } entry_type;

endpackage
`default_nettype wire

[design/xibe_front.sv]
// Front end: classifies one instruction description and packs its bytes.
// Keeps the running code address. Depends on xibe_pkg.
`default_nettype none
module xibe_front import xibe_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire req_type   req_data,
   input  wire logic      take,
   output entry_type      entry
);

   typedef struct packed {
      logic [7:0]  modrm;
      logic        hs;
      logic [7:0]  sib;
      logic [2:0]  dlen;
      logic [31:0] disp;
   } opnd_type;

   function automatic opnd_type opnd(input logic [2:0] kind, input logic [31:0] val,
                                     input logic [2:0] ext, input logic [31:0] off,
                                     input logic [1:0] sc, input logic [2:0] ix);
      opnd_type   o;
      logic [2:0] base;
      logic [2:0] rm;
      logic       use_sib;
      logic       short_disp;
      o          = '0;
      base       = val[2:0];
      use_sib    = (base == 3'd4) || (ix != 3'd4);
      rm         = use_sib ? 3'd4 : base;
      short_disp = (off[31:7] == '0) || (off[31:7] == '1);
      if (kind == K_REG) begin
         o.modrm = {2'b11, ext, base};
      end else if (kind == K_MEM) begin
         o.modrm = {2'b00, ext, 3'd5};
         o.dlen  = 3'd4;
         o.disp  = val;
      end else begin
         o.hs   = use_sib;
         o.sib  = {sc, ix, base};
         o.disp = off;
         if (off == '0 && base != 3'd5) begin
            o.modrm = {2'b00, ext, rm};
         end else if (short_disp) begin
            o.modrm = {2'b01, ext, rm};
            o.dlen  = 3'd1;
         end else begin
            o.modrm = {2'b10, ext, rm};
            o.dlen  = 3'd4;
         end
      end
      return o;
   endfunction

   logic [ADDR_BITS-1:0] code_address_ff, code_address_in;

   logic [5:0]  act;
   logic [2:0]  dk, sk, d, s;
   logic [31:0] dv, sv, off, lab, start;
   logic        ok, none, hm, hi, rel, is_unary, u_allow;
   logic [1:0]  nop;
   logic [7:0]  op0, op1, u_reg, u_mem, a_eax, a_rr;
   logic [2:0]  u_ext, a_ext;
   logic [31:0] imm, immv;
   opnd_type    o;
   logic [IDX_BITS-1:0] len, p_sib, p_disp, p_imm;
   logic [IDX_BITS-1:0] kk;

   always_comb begin
      act   = req_data.action;
      dk    = req_data.dst_kind;
      sk    = req_data.src_kind;
      dv    = req_data.dst_value;
      sv    = req_data.src_value;
      d     = dv[2:0];
      s     = sv[2:0];
      off   = req_data.mem_offset;
      lab   = req_data.label_address;
      start = 32'(code_address_ff);

      // ALU opcode tables, CMP shares the ADD..XOR group.
      unique case (act)
         A_ADD:   begin a_eax = 8'h05; a_rr = 8'h01; a_ext = 3'd0; end
         A_SUB:   begin a_eax = 8'h2D; a_rr = 8'h29; a_ext = 3'd5; end
         A_AND:   begin a_eax = 8'h25; a_rr = 8'h21; a_ext = 3'd4; end
         A_OR:    begin a_eax = 8'h0D; a_rr = 8'h09; a_ext = 3'd1; end
         A_XOR:   begin a_eax = 8'h35; a_rr = 8'h31; a_ext = 3'd6; end
         default: begin a_eax = 8'h3D; a_rr = 8'h39; a_ext = 3'd7; end
      endcase

      ok = 1'b1; none = 1'b0; hm = 1'b0; hi = 1'b0; rel = 1'b0;
      nop = 2'd1; op0 = 8'h00; op1 = 8'h00; imm = sv; o = '0;
      is_unary = 1'b0; u_allow = 1'b1; u_reg = 8'h00; u_mem = 8'h00; u_ext = 3'd0;

      if (act == A_NONE) begin
         none = 1'b1;
      end else if (act == A_PUSH) begin
         if (dk == K_IMM) begin
            op0 = 8'h68; hi = 1'b1; imm = dv;
         end else if (dk == K_REG) begin
            op0 = 8'h50 + {5'd0, d};
         end else begin
            is_unary = 1'b1; u_allow = 1'b0; u_mem = 8'hFF; u_ext = 3'd6;
         end
      end else if (act == A_POP) begin
         if (dk == K_REG) begin
            op0 = 8'h58 + {5'd0, d};
         end else begin
            is_unary = 1'b1; u_allow = 1'b0; u_mem = 8'h8F; u_ext = 3'd0;
         end
      end else if (act == A_MOV) begin
         if (dk == K_REG && sk == K_REG) begin
            op0 = 8'h89; hm = 1'b1; o = opnd(K_REG, dv, s, off, 2'd0, 3'd4);
         end else if (dk == K_MEM && sk == K_REG) begin
            if (s == 3'd0) begin
               op0 = 8'hA3; hi = 1'b1; imm = dv;
            end else begin
               op0 = 8'h89; hm = 1'b1; o = opnd(K_MEM, dv, s, off, 2'd0, 3'd4);
            end
         end else if (dk == K_RMEM && sk == K_REG) begin
            op0 = 8'h89; hm = 1'b1;
            o = opnd(K_RMEM, dv, s, off, req_data.mem_scale, req_data.mem_index);
         end else if (dk == K_RMEM && sk == K_IMM) begin
            op0 = 8'hC7; hm = 1'b1; hi = 1'b1;
            o = opnd(K_RMEM, dv, 3'd0, off, req_data.mem_scale, req_data.mem_index);
         end else if (dk == K_REG && sk == K_MEM) begin
            if (d == 3'd0) begin
               op0 = 8'hA1; hi = 1'b1;
            end else begin
               op0 = 8'h8B; hm = 1'b1; o = opnd(K_MEM, sv, d, off, 2'd0, 3'd4);
            end
         end else if (dk == K_REG && sk == K_RMEM) begin
            op0 = 8'h8B; hm = 1'b1;
            o = opnd(K_RMEM, sv, d, off, req_data.mem_scale, req_data.mem_index);
         end else if (dk == K_REG && sk == K_IMM) begin
            op0 = 8'hB8 + {5'd0, d}; hi = 1'b1;
         end else if (dk == K_REG && sk == K_LABEL) begin
            op0 = 8'hB8 + {5'd0, d}; hi = 1'b1; imm = lab;
         end else if (dk == K_MEM && sk == K_IMM) begin
            op0 = 8'hC7; hm = 1'b1; hi = 1'b1; o = opnd(K_MEM, dv, 3'd0, off, 2'd0, 3'd4);
         end else begin
            ok = 1'b0;
         end
      end else if (act == A_CMP || (act >= A_ADD && act <= A_XOR)) begin
         if (dk == K_REG && sk == K_IMM) begin
            hi = 1'b1;
            if (act == A_ADD && req_data.use_label_imm) imm = lab;
            if (d == 3'd0) begin
               op0 = a_eax;
            end else begin
               op0 = 8'h81; hm = 1'b1; o = opnd(K_REG, dv, a_ext, off, 2'd0, 3'd4);
            end
         end else if (dk == K_REG && sk == K_REG) begin
            op0 = a_rr; hm = 1'b1; o = opnd(K_REG, dv, s, off, 2'd0, 3'd4);
         end else if (dk == K_REG && sk == K_RMEM) begin
            op0 = a_rr + 8'd2; hm = 1'b1;
            o = opnd(K_RMEM, sv, d, off, req_data.mem_scale, req_data.mem_index);
         end else if (dk == K_REG && sk == K_MEM) begin
            op0 = a_rr + 8'd2; hm = 1'b1; o = opnd(K_MEM, sv, d, off, 2'd0, 3'd4);
         end else if (dk == K_RMEM && sk == K_IMM) begin
            op0 = 8'h81; hm = 1'b1; hi = 1'b1;
            o = opnd(K_RMEM, dv, a_ext, off, req_data.mem_scale, req_data.mem_index);
         end else if (dk == K_MEM && sk == K_IMM) begin
            op0 = 8'h81; hm = 1'b1; hi = 1'b1; o = opnd(K_MEM, dv, a_ext, off, 2'd0, 3'd4);
         end else begin
            ok = 1'b0;
         end
      end else if (act == A_JMP || act == A_CALL) begin
         if (dk == K_LABEL) begin
            op0 = (act == A_JMP) ? 8'hE9 : 8'hE8; hi = 1'b1; rel = 1'b1; imm = lab;
         end else begin
            is_unary = 1'b1; u_reg = 8'hFF; u_mem = 8'hFF;
            u_ext = (act == A_JMP) ? 3'd4 : 3'd2;
         end
      end else if (act >= A_JZ && act <= A_JNAE) begin
         if (dk == K_LABEL) begin
            nop = 2'd2; op0 = 8'h0F; hi = 1'b1; rel = 1'b1; imm = lab;
            unique case (act)
               A_JZ:    op1 = 8'h84;
               A_JNE:   op1 = 8'h85;
               A_JG:    op1 = 8'h8F;
               A_JGE:   op1 = 8'h8D;
               A_JL:    op1 = 8'h8C;
               A_JLE:   op1 = 8'h8E;
               A_JNB:   op1 = 8'h83;
               A_JNBE:  op1 = 8'h87;
               A_JNA:   op1 = 8'h86;
               default: op1 = 8'h82;
            endcase
         end else begin
            ok = 1'b0;
         end
      end else if (act == A_NOT || act == A_IDIV) begin
         is_unary = 1'b1; u_reg = 8'hF7; u_mem = 8'hF7;
         u_ext = (act == A_NOT) ? 3'd2 : 3'd7;
      end else if (act == A_IMUL) begin
         if (dk == K_REG && sk == K_IMM) begin
            op0 = 8'h69; hm = 1'b1; hi = 1'b1; o = opnd(K_REG, dv, d, off, 2'd0, 3'd4);
         end else if (dk == K_REG && (sk == K_REG || sk == K_RMEM || sk == K_MEM)) begin
            nop = 2'd2; op0 = 8'h0F; op1 = 8'hAF; hm = 1'b1;
            o = opnd(sk, sv, d, off, req_data.mem_scale, req_data.mem_index);
         end else begin
            ok = 1'b0;
         end
      end else if (act == A_LEA) begin
         if (dk == K_REG && (sk == K_RMEM || sk == K_MEM)) begin
            op0 = 8'h8D; hm = 1'b1;
            o = opnd(sk, sv, d, off, req_data.mem_scale, req_data.mem_index);
         end else begin
            ok = 1'b0;
         end
      end else if (act >= A_FLD && act <= A_FDIV) begin
         is_unary = 1'b1;
         unique case (act)
            A_FLD:   begin u_reg = 8'hD9; u_mem = 8'hDD; u_ext = 3'd0; end
            A_FST:   begin u_reg = 8'hDD; u_mem = 8'hDD; u_ext = 3'd2; end
            A_FSTP:  begin u_reg = 8'hDD; u_mem = 8'hDD; u_ext = 3'd3; end
            A_FILD:  begin u_allow = 1'b0; u_mem = 8'hDB; u_ext = 3'd0; end
            A_FADD:  begin u_reg = 8'hD8; u_mem = 8'hDC; u_ext = 3'd0; end
            A_FSUB:  begin u_reg = 8'hD8; u_mem = 8'hDC; u_ext = 3'd4; end
            A_FMUL:  begin u_reg = 8'hD8; u_mem = 8'hDC; u_ext = 3'd1; end
            default: begin u_reg = 8'hD8; u_mem = 8'hDC; u_ext = 3'd6; end
         endcase
      end else if (act == A_RET)      op0 = 8'hC3;
      else if (act == A_LEAVE)        op0 = 8'hC9;
      else if (act == A_NOP)          op0 = 8'h90;
      else if (act == A_PUSHAD)       op0 = 8'h60;
      else if (act == A_POPAD)        op0 = 8'h61;
      else if (act == A_FUCOMPP) begin nop = 2'd2; op0 = 8'hDA; op1 = 8'hE9; end
      else if (act == A_FNSTSW)  begin nop = 2'd2; op0 = 8'hDF; op1 = 8'hE0; end
      else if (act == A_SAHF)         op0 = 8'h9E;
      else if (act == A_FSQRT)   begin nop = 2'd2; op0 = 8'hD9; op1 = 8'hFA; end
      else if (act == A_INT3)         op0 = 8'hCC;
      else if (act == A_PUSHF)        op0 = 8'h9C;
      else if (act == A_POPF)         op0 = 8'h9D;
      else ok = 1'b0;

      // Single-operand group: register form when allowed, else memory forms.
      if (is_unary) begin
         if (dk == K_REG && u_allow) begin
            op0 = u_reg; hm = 1'b1; o = opnd(K_REG, dv, u_ext, off, 2'd0, 3'd4);
         end else if (dk == K_RMEM || dk == K_MEM) begin
            op0 = u_mem; hm = 1'b1;
            o = opnd(dk, dv, u_ext, off, req_data.mem_scale, req_data.mem_index);
         end else begin
            ok = 1'b0;
         end
      end

      p_sib  = IDX_BITS'(nop) + IDX_BITS'(hm);
      p_disp = p_sib + IDX_BITS'(o.hs);
      p_imm  = p_disp + IDX_BITS'(o.dlen);
      len    = p_imm + (hi ? IDX_BITS'(4) : IDX_BITS'(0));
      // Relative targets are measured from the end of this instruction.
      immv   = rel ? (imm - start - 32'(len)) : imm;

      for (int k = 0; k < MAX_BYTES; k++) begin
         kk = IDX_BITS'(k);
         if (kk == '0) begin
            entry.bytes[k] = op0;
         end else if (kk == IDX_BITS'(1) && nop == 2'd2) begin
            entry.bytes[k] = op1;
         end else if (hm && kk == IDX_BITS'(nop)) begin
            entry.bytes[k] = o.modrm;
         end else if (o.hs && kk == p_sib) begin
            entry.bytes[k] = o.sib;
         end else if (kk < p_imm) begin
            entry.bytes[k] = o.disp[8 * (2'(kk - p_disp)) +: 8];
         end else begin
            entry.bytes[k] = immv[8 * (2'(kk - p_imm)) +: 8];
         end
      end

      entry.start  = start;
      entry.len    = len;
      entry.status = none ? ST_NONE : (ok ? ST_OK : ST_ERR);

      code_address_in = code_address_ff;
      if (take && entry.status == ST_OK) begin
         code_address_in = code_address_ff + ADDR_BITS'(len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_address_ff <= '0;
      end else begin
         code_address_ff <= code_address_in;
      end
   end

endmodule
`default_nettype wire

[design/xibe_queue.sv]
// Two-entry queue of encoded instructions between the front and back ends.
// Depends on xibe_pkg.
`default_nettype none
module xibe_queue import xibe_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           empty,
   output entry_type      head
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

[design/xibe_back.sv]
// Back end: walks the queued bytes one per cycle into the result register while rsp_stall is low.
// Depends on xibe_pkg.
`default_nettype none
module xibe_back import xibe_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire entry_type head,
   input  wire logic      empty,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_data
);

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                load, last;

   always_comb begin
      load = !rsp_valid_ff || !rsp_stall;
      last = (head.status != ST_OK) || (idx_ff == head.len - IDX_BITS'(1));
      pop  = load && !empty && last;

      rsp_data_in.code_byte     = (head.status == ST_OK) ? head.bytes[idx_ff] : 8'h00;
      rsp_data_in.last_byte     = last;
      rsp_data_in.status        = head.status;
      rsp_data_in.instr_address = head.start;

      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = !empty;
         if (!empty) begin
            idx_in = last ? '0 : idx_ff + IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && !empty) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[design/x86_instruction_byte_encoder.sv]
// Encodes 32-bit x86 instruction descriptions into machine-code bytes.
// Usage:
//   req_valid/req_stall/req_data carry one instruction description per
//   transfer. rsp_valid/rsp_stall/rsp_data return its bytes, one byte per
//   transfer, with last_byte set on the final one. NONE and invalid operand
//   combinations return a single transfer with status set and no byte.
//   instr_address gives the running code offset where the instruction starts.
// The request's entry is registered in the queue; its first byte then passes
//   through the result register to rsp.
// Result bytes leave the single result output register at one per cycle while
//   rsp_stall is low; an instruction has 1 to 11 bytes. A new request is taken
//   every cycle while the two-entry queue between the front and back ends has
//   room.
// Reset clears the code address to zero and empties the queue and output.
// When the receiver stalls, the current result holds, the queue fills, and
//   req_stall rises once both queue entries are occupied.
// Depends on xibe_pkg, xibe_front, xibe_queue and xibe_back.
`default_nettype none
module x86_instruction_byte_encoder import xibe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   entry_type new_entry, head;
   logic      full, empty, pop, push;

   assign req_stall = full;
   assign push      = req_valid && !full;

   xibe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .take     (push),
      .entry    (new_entry)
   );

   xibe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (new_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   xibe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[tb/x86_instruction_byte_encoder_checker.sv]
// Checker for the x86 instruction byte encoder: watches both channels,
// predicts the byte stream of each accepted instruction and compares results.
// Depends on xibe_pkg.
`timescale 1ns / 100ps
`default_nettype none
module x86_instruction_byte_encoder_checker import xibe_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data,
   output int          failures,
   output int          pending
);

   rsp_type     expected_bytes[$];
   logic [31:0] code_address;
   logic [7:0]  enc[$];
   req_type     cur;

   function automatic logic [7:0] modrm(logic [1:0] md, logic [2:0] rg, logic [2:0] rm);
      return {md, rg, rm};
   endfunction

   task automatic emit32(logic [31:0] v);
      enc.push_back(v[7:0]); enc.push_back(v[15:8]);
      enc.push_back(v[23:16]); enc.push_back(v[31:24]);
   endtask

   task automatic emit_rmem(logic [2:0] rg, logic [31:0] basev);
      logic [2:0]  base;
      logic        sib;
      logic [31:0] off;
      base = basev[2:0];
      off = cur.mem_offset;
      sib = (base == 3'd4) || (cur.mem_index != 3'd4);
      if (off == 0 && base != 3'd5) begin
         enc.push_back(modrm(2'd0, rg, sib ? 3'd4 : base));
         if (sib) enc.push_back({cur.mem_scale, cur.mem_index, base});
      end else if (off <= 32'd127 || off >= 32'hFFFFFF80) begin
         enc.push_back(modrm(2'd1, rg, sib ? 3'd4 : base));
         if (sib) enc.push_back({cur.mem_scale, cur.mem_index, base});
         enc.push_back(off[7:0]);
      end else begin
         enc.push_back(modrm(2'd2, rg, sib ? 3'd4 : base));
         if (sib) enc.push_back({cur.mem_scale, cur.mem_index, base});
         emit32(off);
      end
   endtask

   task automatic emit_abs(logic [2:0] rg, logic [31:0] a);
      enc.push_back(modrm(2'd0, rg, 3'd5));
      emit32(a);
   endtask

   // Single-operand forms: register, register-relative memory or absolute memory.
   task automatic emit_unary(logic [7:0] op_reg, logic [7:0] op_mem, logic [2:0] ext,
                             logic allow_reg, output logic ok);
      ok = 1'b1;
      if (cur.dst_kind == K_REG && allow_reg) begin
         enc.push_back(op_reg); enc.push_back(modrm(2'd3, ext, cur.dst_value[2:0]));
      end else if (cur.dst_kind == K_RMEM) begin
         enc.push_back(op_mem); emit_rmem(ext, cur.dst_value);
      end else if (cur.dst_kind == K_MEM) begin
         enc.push_back(op_mem); emit_abs(ext, cur.dst_value);
      end else ok = 1'b0;
   endtask

   task automatic predict_encoding(req_type r);
      logic [7:0]  jcc[10];
      logic [2:0]  ext6[6];
      logic [7:0]  eax6[6], rr6[6], rm6[6];
      logic        ok;
      logic [2:0]  d, s;
      logic [31:0] dv, sv, imm, start;
      int          a;
      rsp_type     e;
      jcc = '{8'h84, 8'h85, 8'h8F, 8'h8D, 8'h8C, 8'h8E, 8'h83, 8'h87, 8'h86, 8'h82};
      ext6 = '{3'd0, 3'd5, 3'd4, 3'd1, 3'd6, 3'd7};
      eax6 = '{8'h05, 8'h2D, 8'h25, 8'h0D, 8'h35, 8'h3D};
      rr6 = '{8'h01, 8'h29, 8'h21, 8'h09, 8'h31, 8'h39};
      rm6 = '{8'h03, 8'h2B, 8'h23, 8'h0B, 8'h33, 8'h3B};
      cur = r;
      enc.delete();
      ok = 1'b1;
      dv = r.dst_value; sv = r.src_value;
      d = dv[2:0]; s = sv[2:0];
      start = code_address;
      if (r.action == A_NONE) begin
         e = '{code_byte: 8'd0, last_byte: 1'b1, status: ST_NONE, instr_address: start};
         expected_bytes.push_back(e);
         return;
      end
      case (r.action)
         A_PUSH:
            if (r.dst_kind == K_IMM) begin enc.push_back(8'h68); emit32(dv); end
            else if (r.dst_kind == K_REG) enc.push_back(8'h50 + d);
            else emit_unary(8'h00, 8'hFF, 3'd6, 1'b0, ok);
         A_POP:
            if (r.dst_kind == K_REG) enc.push_back(8'h58 + d);
            else emit_unary(8'h00, 8'h8F, 3'd0, 1'b0, ok);
         A_MOV:
            if (r.dst_kind == K_REG && r.src_kind == K_REG) begin
               enc.push_back(8'h89); enc.push_back(modrm(2'd3, s, d));
            end else if (r.dst_kind == K_MEM && r.src_kind == K_REG) begin
               if (s == 0) begin enc.push_back(8'hA3); emit32(dv); end
               else begin enc.push_back(8'h89); emit_abs(s, dv); end
            end else if (r.dst_kind == K_RMEM && r.src_kind == K_REG) begin
               enc.push_back(8'h89); emit_rmem(s, dv);
            end else if (r.dst_kind == K_RMEM && r.src_kind == K_IMM) begin
               enc.push_back(8'hC7); emit_rmem(3'd0, dv); emit32(sv);
            end else if (r.dst_kind == K_REG && r.src_kind == K_MEM) begin
               if (d == 0) begin enc.push_back(8'hA1); emit32(sv); end
               else begin enc.push_back(8'h8B); emit_abs(d, sv); end
            end else if (r.dst_kind == K_REG && r.src_kind == K_RMEM) begin
               enc.push_back(8'h8B); emit_rmem(d, sv);
            end else if (r.dst_kind == K_REG && r.src_kind == K_IMM) begin
               enc.push_back(8'hB8 + d); emit32(sv);
            end else if (r.dst_kind == K_REG && r.src_kind == K_LABEL) begin
               enc.push_back(8'hB8 + d); emit32(r.label_address);
            end else if (r.dst_kind == K_MEM && r.src_kind == K_IMM) begin
               enc.push_back(8'hC7); emit_abs(3'd0, dv); emit32(sv);
            end else ok = 1'b0;
         A_JMP, A_CALL:
            if (r.dst_kind == K_LABEL) begin
               enc.push_back(r.action == A_JMP ? 8'hE9 : 8'hE8);
               emit32(r.label_address - start - 32'd5);
            end else emit_unary(8'hFF, 8'hFF, r.action == A_JMP ? 3'd4 : 3'd2, 1'b1, ok);
         A_NOT:  emit_unary(8'hF7, 8'hF7, 3'd2, 1'b1, ok);
         A_IDIV: emit_unary(8'hF7, 8'hF7, 3'd7, 1'b1, ok);
         A_IMUL:
            if (r.dst_kind == K_REG && r.src_kind == K_IMM) begin
               enc.push_back(8'h69); enc.push_back(modrm(2'd3, d, d)); emit32(sv);
            end else if (r.dst_kind == K_REG && r.src_kind == K_REG) begin
               enc.push_back(8'h0F); enc.push_back(8'hAF); enc.push_back(modrm(2'd3, d, s));
            end else if (r.dst_kind == K_REG && r.src_kind == K_RMEM) begin
               enc.push_back(8'h0F); enc.push_back(8'hAF); emit_rmem(d, sv);
            end else if (r.dst_kind == K_REG && r.src_kind == K_MEM) begin
               enc.push_back(8'h0F); enc.push_back(8'hAF); emit_abs(d, sv);
            end else ok = 1'b0;
         A_LEA:
            if (r.dst_kind == K_REG && r.src_kind == K_RMEM) begin
               enc.push_back(8'h8D); emit_rmem(d, sv);
            end else if (r.dst_kind == K_REG && r.src_kind == K_MEM) begin
               enc.push_back(8'h8D); emit_abs(d, sv);
            end else ok = 1'b0;
         A_FLD:  emit_unary(8'hD9, 8'hDD, 3'd0, 1'b1, ok);
         A_FST:  emit_unary(8'hDD, 8'hDD, 3'd2, 1'b1, ok);
         A_FSTP: emit_unary(8'hDD, 8'hDD, 3'd3, 1'b1, ok);
         A_FILD: emit_unary(8'h00, 8'hDB, 3'd0, 1'b0, ok);
         A_FADD: emit_unary(8'hD8, 8'hDC, 3'd0, 1'b1, ok);
         A_FSUB: emit_unary(8'hD8, 8'hDC, 3'd4, 1'b1, ok);
         A_FMUL: emit_unary(8'hD8, 8'hDC, 3'd1, 1'b1, ok);
         A_FDIV: emit_unary(8'hD8, 8'hDC, 3'd6, 1'b1, ok);
         A_RET:    enc.push_back(8'hC3);
         A_LEAVE:  enc.push_back(8'hC9);
         A_NOP:    enc.push_back(8'h90);
         A_PUSHAD: enc.push_back(8'h60);
         A_POPAD:  enc.push_back(8'h61);
         A_FUCOMPP: begin enc.push_back(8'hDA); enc.push_back(8'hE9); end
         A_FNSTSW:  begin enc.push_back(8'hDF); enc.push_back(8'hE0); end
         A_SAHF:    enc.push_back(8'h9E);
         A_FSQRT:   begin enc.push_back(8'hD9); enc.push_back(8'hFA); end
         A_INT3:    enc.push_back(8'hCC);
         A_PUSHF:   enc.push_back(8'h9C);
         A_POPF:    enc.push_back(8'h9D);
         default:
            if (r.action == A_CMP || (r.action >= A_ADD && r.action <= A_XOR)) begin
               a = (r.action == A_CMP) ? 5 : int'(r.action - A_ADD);
               imm = (r.action == A_ADD && r.use_label_imm) ? r.label_address : sv;
               if (r.dst_kind == K_REG && r.src_kind == K_IMM) begin
                  if (d == 0) enc.push_back(eax6[a]);
                  else begin enc.push_back(8'h81); enc.push_back(modrm(2'd3, ext6[a], d)); end
                  emit32(imm);
               end else if (r.dst_kind == K_REG && r.src_kind == K_REG) begin
                  enc.push_back(rr6[a]); enc.push_back(modrm(2'd3, s, d));
               end else if (r.dst_kind == K_REG && r.src_kind == K_RMEM) begin
                  enc.push_back(rm6[a]); emit_rmem(d, sv);
               end else if (r.dst_kind == K_REG && r.src_kind == K_MEM) begin
                  enc.push_back(rm6[a]); emit_abs(d, sv);
               end else if (r.dst_kind == K_RMEM && r.src_kind == K_IMM) begin
                  enc.push_back(8'h81); emit_rmem(ext6[a], dv); emit32(sv);
               end else if (r.dst_kind == K_MEM && r.src_kind == K_IMM) begin
                  enc.push_back(8'h81); emit_abs(ext6[a], dv); emit32(sv);
               end else ok = 1'b0;
            end else if (r.action >= A_JZ && r.action <= A_JNAE) begin
               if (r.dst_kind == K_LABEL) begin
                  enc.push_back(8'h0F); enc.push_back(jcc[r.action - A_JZ]);
                  emit32(r.label_address - start - 32'd6);
               end else ok = 1'b0;
            end else ok = 1'b0;
      endcase
      if (!ok || enc.size() == 0 || enc.size() > 11) begin
         e = '{code_byte: 8'd0, last_byte: 1'b1, status: ST_ERR, instr_address: start};
         expected_bytes.push_back(e);
         return;
      end
      foreach (enc[i]) begin
         e = '{code_byte: enc[i], last_byte: (i == enc.size() - 1), status: ST_OK,
               instr_address: start};
         expected_bytes.push_back(e);
      end
      code_address = start + 32'(enc.size());
   endtask

   assign pending = expected_bytes.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         code_address <= '0;
         expected_bytes.delete();
         failures <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("result transfer with nothing expected: %p", rsp_data);
               failures <= failures + 1;
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_data !== e) begin
                  failures <= failures + 1;
                  if (rsp_data.code_byte !== e.code_byte)
                     $error("code_byte expected %h actual %h", e.code_byte, rsp_data.code_byte);
                  if (rsp_data.last_byte !== e.last_byte)
                     $error("last_byte expected %b actual %b", e.last_byte, rsp_data.last_byte);
                  if (rsp_data.status !== e.status)
                     $error("status expected %0d actual %0d", e.status, rsp_data.status);
                  if (rsp_data.instr_address !== e.instr_address)
                     $error("instr_address expected %h actual %h",
                            e.instr_address, rsp_data.instr_address);
               end
            end
         end
         // Prediction after the pop, so a same-cycle request does not confuse order.
         if (req_valid && !req_stall) predict_encoding(req_data);
      end
   end

endmodule
`default_nettype wire

[tb/x86_instruction_byte_encoder_test.sv]
// Testbench top for the x86 instruction byte encoder: drives directed and
// random instruction descriptions with random idling and gives the verdict.
// Depends on xibe_pkg, the encoder and x86_instruction_byte_encoder_checker.
`timescale 1ns / 100ps
`default_nettype none
module x86_instruction_byte_encoder_test;
   import xibe_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      cycle_count = 0;
   logic    steady = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   x86_instruction_byte_encoder DUT (.*);

   x86_instruction_byte_encoder_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver stalls at random except during the steady stretch.
   always @(posedge clock)
      rsp_stall <= steady ? 1'b0 : ($urandom_range(99) < 24);

   function automatic logic [31:0] pick_offset();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'd127;
         2: return 32'hFFFFFF80;
         3: return 32'd128;
         4: return $urandom_range(255) - 128;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_instruction();
      req_type r;
      r.action = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(45));
      r.dst_kind = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      r.src_kind = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      r.dst_value = $urandom_range(1) ? 32'($urandom_range(7)) : $urandom;
      r.src_value = $urandom_range(1) ? 32'($urandom_range(7)) : $urandom;
      r.mem_offset = pick_offset();
      r.mem_scale = 2'($urandom_range(3));
      r.mem_index = $urandom_range(1) ? 3'd4 : 3'($urandom_range(7));
      r.label_address = $urandom;
      r.use_label_imm = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic req_type make_instr(logic [5:0] act, logic [2:0] dk, logic [31:0] dv,
                                          logic [2:0] sk, logic [31:0] sv,
                                          logic [31:0] off, logic [2:0] idx);
      req_type r;
      r = random_instruction();
      r.action = act; r.dst_kind = dk; r.dst_value = dv;
      r.src_kind = sk; r.src_value = sv; r.mem_offset = off; r.mem_index = idx;
      return r;
   endfunction

   task automatic send(req_type r);
      while ($urandom_range(99) < 24 && !steady) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // Directed: short EAX forms, SIB, displacement sizes, jumps, errors and NONE.
      send(make_instr(A_NONE, K_NONE, 0, K_NONE, 0, 0, 3'd4));
      send(make_instr(A_MOV, K_REG, 0, K_IMM, 32'h7FFFFFFF, 0, 3'd4));
      send(make_instr(A_MOV, K_MEM, 32'h80000000, K_REG, 0, 0, 3'd4));
      send(make_instr(A_MOV, K_REG, 3, K_RMEM, 4, 0, 3'd4));
      send(make_instr(A_MOV, K_REG, 3, K_RMEM, 5, 0, 3'd4));
      send(make_instr(A_MOV, K_RMEM, 1, K_IMM, 32'hFFFFFFFF, 32'h80000000, 3'd6));
      send(make_instr(A_ADD, K_REG, 0, K_IMM, 5, 127, 3'd4));
      send(make_instr(A_CMP, K_RMEM, 2, K_IMM, 9, 32'hFFFFFF80, 3'd4));
      send(make_instr(A_XOR, K_MEM, 32'hFFFFFFFF, K_IMM, 1, 0, 3'd4));
      send(make_instr(A_JMP, K_LABEL, 0, K_NONE, 0, 0, 3'd4));
      send(make_instr(A_CALL, K_REG, 7, K_NONE, 0, 0, 3'd4));
      send(make_instr(A_JZ, K_LABEL, 0, K_NONE, 0, 0, 3'd4));
      send(make_instr(A_JNAE, K_REG, 0, K_NONE, 0, 0, 3'd4));
      send(make_instr(A_IMUL, K_RMEM, 0, K_IMM, 0, 0, 3'd4));
      send(make_instr(A_IMUL, K_REG, 2, K_REG, 6, 0, 3'd4));
      send(make_instr(A_LEA, K_REG, 1, K_RMEM, 4, 128, 3'd0));
      send(make_instr(A_FILD, K_REG, 0, K_NONE, 0, 0, 3'd4));
      send(make_instr(A_FDIV, K_RMEM, 5, K_NONE, 0, 0, 3'd4));
      send(make_instr(A_FUCOMPP, K_NONE, 0, K_NONE, 0, 0, 3'd4));
      // An action number past the last operation.
      send(make_instr(6'd63, K_REG, 0, K_REG, 0, 0, 3'd4));
      // Operand kinds past the last defined kind.
      send(make_instr(A_MOV, 3'd7, 0, 3'd6, 0, 0, 3'd4));
      for (k = 0; k < 80; k++) begin
         if (k == 30) steady <= 1'b1;
         if (k == 55) steady <= 1'b0;
         send(random_instruction());
      end
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire

[x86_instruction_byte_encoder.f]
design/xibe_pkg.sv
design/xibe_front.sv
design/xibe_queue.sv
design/xibe_back.sv
design/x86_instruction_byte_encoder.sv
tb/x86_instruction_byte_encoder_checker.sv
tb/x86_instruction_byte_encoder_test.sv
